FILE: hdl/pmqs_pkg.sv
// Types and constants shared by the priority queue scheduler modules.
package pmqs_pkg;

  localparam int unsigned TaskW = 8;
  localparam int unsigned PrioW = 3;

  typedef enum logic [1:0] {
    ACT_SCHEDULE   = 2'd0,
    ACT_REMOVE     = 2'd1,
    ACT_TAKE       = 2'd2,
    ACT_RESCHEDULE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DROP,
    S_SCHED,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [TaskW-1:0] task_id;
    logic [PrioW-1:0] task_priority;
  } in_item_t;

  typedef struct packed {
    logic [TaskW-1:0] out_task;
    logic             out_valid;
    logic signed [3:0] active_priority;
    logic [1:0]       status;
  } out_item_t;

  // Command from the controller to every queue cell.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             drop;
    logic [TaskW-1:0] tid;
  } cell_cmd_t;

endpackage

FILE: hdl/pmqs_cell.sv
// One queue cell: a single task slot of a level queue, shifting towards the head.
module pmqs_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sel,
  input  pmqs_pkg::cell_cmd_t   cmd,
  input  logic                  is_tail,
  input  logic                  nb_full,
  input  logic [pmqs_pkg::TaskW-1:0] nb_task,
  input  logic                  nb_drop,
  output logic                  full,
  output logic [pmqs_pkg::TaskW-1:0] task_q,
  output logic                  drop_out
);
  import pmqs_pkg::*;

  logic             full_next;
  logic [TaskW-1:0] task_next;
  logic             kill;

  // mark this cell when it holds the id; nb_drop flags a match nearer the head
  assign kill     = full && (task_q == cmd.tid);
  assign drop_out = nb_drop;

  // choose the next content of this slot; a drop pass removes the first copy only
  always_comb begin
    full_next = full;
    task_next = task_q;
    if (sel) begin
      if (cmd.pop) begin
        full_next = nb_full;
        task_next = nb_task;
      end else if (cmd.push && !full && is_tail) begin
        full_next = 1'b1;
        task_next = cmd.tid;
      end else if (cmd.drop && (kill || drop_out)) begin
        full_next = nb_full;
        task_next = nb_task;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
    task_q <= task_next;
  end

endmodule

FILE: hdl/priority_multi_queue_scheduler_unit.sv
// Top level of the strict priority multi queue scheduler.
//
// channel | direction | handshake       | payload
// command | in        | start / busy    | cmd  (in_item_t)
// result  | out       | done strobe     | res  (out_item_t)
//
// Schedule and take next pass through the schedule state and the done state
// before the registered result strobe. Remove scans one level per cycle from
// the top, then drops one copy of the id per cycle from the first level that
// holds it, until none is left, plus a final check; reschedule then adds the
// schedule state.
// Reset empties all queues.
// The receiver cannot stall: done is high for one cycle per command.
module priority_multi_queue_scheduler_unit #(
  parameter int unsigned LEVELS      = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pmqs_pkg::in_item_t  cmd,
  output logic                busy,
  output logic                done,
  output pmqs_pkg::out_item_t res
);
  import pmqs_pkg::*;

  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  state_t state, state_next;
  in_item_t item;
  logic [LW-1:0] lvl_in;
  logic [LW-1:0] scan;
  logic [LEVELS-1:0] nonempty;
  logic [LEVELS-1:0] hit;
  logic [LEVELS-1:0] qfull;
  logic [TaskW-1:0] head_task [LEVELS];
  cell_cmd_t ccmd;
  logic [LEVELS-1:0] csel;
  logic signed [LW:0] cur, cur_next;
  logic [1:0] st, rs;
  logic [TaskW-1:0] otask;
  logic ovalid;

  function automatic state_t found_sched();
    return (item.action == ACT_RESCHEDULE) ? S_SCHED : S_DONE;
  endfunction

  // clamp the requested level into range
  always_comb begin
    if (32'(item.task_priority) >= LEVELS) lvl_in = LW'(LEVELS - 1);
    else lvl_in = LW'(item.task_priority);
  end

  // one row of cells per level
  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    logic [QUEUE_DEPTH-1:0] f;
    logic [QUEUE_DEPTH-1:0] dr;
    logic [TaskW-1:0] t [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] m;
    for (genvar c = 0; c < QUEUE_DEPTH; c++) begin : g_c
      logic tail;
      logic nf;
      logic [TaskW-1:0] nt;
      logic nd;
      if (c == 0) begin : g_h
        assign tail = 1'b1;
        assign nd   = 1'b0;
      end else begin : g_b
        assign tail = f[c-1];
        assign nd   = dr[c-1] || m[c-1];
      end
      if (c == QUEUE_DEPTH - 1) begin : g_e
        assign nf = 1'b0;
        assign nt = '0;
      end else begin : g_n
        assign nf = f[c+1];
        assign nt = t[c+1];
      end
      assign m[c] = f[c] && (t[c] == ccmd.tid);
      pmqs_cell u_cell (
        .clk(clk), .rst(rst), .sel(csel[l]), .cmd(ccmd), .is_tail(tail),
        .nb_full(nf), .nb_task(nt), .nb_drop(nd), .full(f[c]), .task_q(t[c]),
        .drop_out(dr[c])
      );
    end
    assign nonempty[l]  = f[0];
    assign qfull[l]     = f[QUEUE_DEPTH-1];
    assign hit[l]       = |m;
    assign head_task[l] = t[0];
  end

  // highest non-empty level, or -1
  always_comb begin
    cur_next = '1;
    for (int i = 0; i < LEVELS; i++) begin
      if (nonempty[i]) cur_next = (LW+1)'(i);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) begin
        case (action_t'(cmd.action))
          ACT_REMOVE, ACT_RESCHEDULE: state_next = S_SCAN;
          default: state_next = S_SCHED;
        endcase
      end
      S_SCAN: begin
        if (cur < 0 || (scan == '0 && !hit[scan])) state_next = found_sched();
        else if (hit[scan] && nonempty[scan]) state_next = S_DROP;
        else state_next = S_SCAN;
      end
      // repeat the drop pass until no copy of the id is left in the row
      S_DROP:  state_next = hit[scan] ? S_DROP : found_sched();
      S_SCHED: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs to the cells
  always_comb begin
    ccmd = '0;
    csel = '0;
    ccmd.tid = item.task_id;
    case (state)
      S_DROP: begin
        ccmd.drop = 1'b1;
        csel[scan] = 1'b1;
      end
      S_SCHED: begin
        if (item.action == ACT_TAKE) begin
          if (cur >= 0) begin
            ccmd.pop = 1'b1;
            csel[cur[LW-1:0]] = 1'b1;
          end
        end else if (!qfull[lvl_in]) begin
          ccmd.push = 1'b1;
          csel[lvl_in] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign cur  = cur_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_DONE);
    end
    if (state == S_IDLE && start) begin
      item   <= cmd;
      otask  <= '0;
      ovalid <= 1'b0;
      rs     <= ST_NOT_FOUND;
      st     <= ST_OK;
    end
    // walk levels downward from the top
    if (state == S_IDLE) scan <= LW'(LEVELS - 1);
    else if (state == S_SCAN && !(hit[scan] && nonempty[scan]) && scan != '0)
      scan <= scan - 1'b1;
    if (state == S_DROP) rs <= ST_OK;
    if (state == S_SCHED) begin
      if (item.action == ACT_TAKE) begin
        if (cur < 0) st <= ST_EMPTY;
        else begin
          otask  <= head_task[cur[LW-1:0]];
          ovalid <= 1'b1;
        end
      end else if (qfull[lvl_in]) st <= ST_FULL;
      else if (item.action == ACT_RESCHEDULE) st <= rs;
    end
    if (state == S_DONE && (item.action == ACT_REMOVE)) st <= rs;
    res.out_task        <= otask;
    res.out_valid       <= ovalid;
    res.active_priority <= 4'(cur);
    res.status          <= (state == S_DONE && item.action == ACT_REMOVE) ? rs : st;
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("command not taken");
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    (done && res.out_valid) |-> res.status == ST_OK) else $error("bad status");

endmodule

FILE: test/tb_priority_multi_queue_scheduler_unit.sv
// Testbench for the strict priority multi queue scheduler: directed and random commands checked against a local model.
`timescale 1ns / 100ps

module tb_priority_multi_queue_scheduler_unit;
  import pmqs_pkg::*;

  localparam int NLEV  = 8;
  localparam int DEPTH = 16;

  // Scheduler model and queue of expected results
  class sched_scoreboard;
    logic [7:0] ring [NLEV][DEPTH];
    int unsigned head [NLEV];
    int unsigned fill [NLEV];
    int unsigned waiting [NLEV];
    int wtop;
    int serving;
    out_item_t want_q [$];
    int errors;
    int reported;

    function void clear();
      for (int l = 0; l < NLEV; l++) begin
        head[l] = 0;
        fill[l] = 0;
        waiting[l] = 0;
      end
      wtop = -1;
      serving = -1;
      want_q.delete();
      errors = 0;
      reported = 0;
    endfunction

    function int unsigned slot(int unsigned l, int unsigned k);
      return (head[l] + k) % DEPTH;
    endfunction

    function void step_down();
      if (wtop >= 0) begin
        serving = waiting[wtop];
        wtop--;
      end else begin
        serving = -1;
      end
    endfunction

    function status_t enqueue(logic [7:0] t, int unsigned l);
      int ix;
      if (fill[l] >= DEPTH) return ST_FULL;
      ring[l][slot(l, fill[l])] = t;
      fill[l]++;
      if (int'(l) == serving) return ST_OK;
      if (int'(l) > serving) begin
        if (serving != -1 && wtop < NLEV - 1) begin
          wtop++;
          waiting[wtop] = serving;
        end
        serving = l;
        return ST_OK;
      end
      for (ix = wtop; ix >= 0; ix--) begin
        if (waiting[ix] > l) continue;
        if (waiting[ix] == l) return ST_OK;
        break;
      end
      if (wtop >= NLEV - 1) return ST_OK;
      for (int j = wtop; j > ix; j--) waiting[j + 1] = waiting[j];
      waiting[ix + 1] = l;
      wtop++;
      return ST_OK;
    endfunction

    function bit purge(int unsigned l, logic [7:0] t);
      int unsigned w;
      bit hit;
      logic [7:0] v;
      w = 0;
      hit = 0;
      for (int unsigned r = 0; r < fill[l]; r++) begin
        v = ring[l][slot(l, r)];
        if (v == t) hit = 1;
        else begin
          ring[l][slot(l, w)] = v;
          w++;
        end
      end
      fill[l] = w;
      return hit;
    endfunction

    function status_t withdraw(logic [7:0] t);
      int pos, nxt, l;
      pos = -1;
      nxt = wtop;
      l = serving;
      if (l < 0) return ST_NOT_FOUND;
      forever begin
        if (purge(l, t)) begin
          if (fill[l] == 0) begin
            if (pos < 0) step_down();
            else begin
              for (int i = pos; i < wtop; i++) waiting[i] = waiting[i + 1];
              wtop--;
            end
          end
          return ST_OK;
        end
        if (nxt < 0) return ST_NOT_FOUND;
        pos = nxt;
        l = waiting[nxt];
        nxt--;
      end
    endfunction

    // Note an accepted command and queue its expected result
    function void note_command(in_item_t c);
      out_item_t r;
      status_t rs, ss;
      int unsigned l;
      l = c.task_priority;
      r = '0;
      r.status = ST_OK;
      case (action_t'(c.action))
        ACT_SCHEDULE: r.status = enqueue(c.task_id, l);
        ACT_REMOVE: r.status = withdraw(c.task_id);
        ACT_TAKE: begin
          if (serving < 0) r.status = ST_EMPTY;
          else if (fill[serving] == 0) begin
            step_down();
            r.status = ST_EMPTY;
          end else begin
            r.out_task = ring[serving][slot(serving, 0)];
            r.out_valid = 1'b1;
            head[serving] = (head[serving] + 1) % DEPTH;
            fill[serving]--;
            if (fill[serving] == 0) step_down();
          end
        end
        default: begin
          rs = withdraw(c.task_id);
          ss = enqueue(c.task_id, l);
          r.status = (ss == ST_FULL) ? ST_FULL : rs;
        end
      endcase
      r.active_priority = 4'(serving);
      want_q.push_back(r);
    endfunction

    // Compare a result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t w;
      if (want_q.size() == 0) begin
        errors++;
        if (reported++ < 10) $display("unexpected result %h", got);
        return;
      end
      w = want_q.pop_front();
      if (got.out_task !== w.out_task || got.out_valid !== w.out_valid ||
          got.active_priority !== w.active_priority || got.status !== w.status) begin
        errors++;
        if (reported++ < 10)
          $display("mismatch: task %h/%h valid %b/%b prio %0d/%0d status %0d/%0d",
                   w.out_task, got.out_task, w.out_valid, got.out_valid,
                   w.active_priority, got.active_priority, w.status, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_item_t cmd = '0;
  logic busy, done;
  out_item_t res;
  sched_scoreboard sb;
  bit quiet;

  priority_multi_queue_scheduler_unit dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .res(res)
  );

  always #4 clk = ~clk;

  // Check every result strobe
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(res);
  end

  // Hand one command over and wait until the scheduler is no longer busy
  task automatic issue(action_t a, logic [7:0] t, logic [2:0] p);
    in_item_t c;
    c.action = a;
    c.task_id = t;
    c.task_priority = p;
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      cmd <= {2'($urandom), TaskW'($urandom), PrioW'($urandom)};
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Random command, mostly schedules and takes over a small pool of ids
  task automatic random_command();
    int k;
    logic [7:0] t;
    k = $urandom_range(0, 9);
    t = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
    if (k < 4) issue(ACT_SCHEDULE, t, 3'($urandom));
    else if (k < 6) issue(ACT_TAKE, t, 3'($urandom));
    else if (k < 8) issue(ACT_REMOVE, t, 3'($urandom));
    else issue(ACT_RESCHEDULE, t, 3'($urandom));
  endtask

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int waited;
    sb = new();
    sb.clear();
    quiet = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty cases, extremes, full queue, duplicates
    issue(ACT_TAKE, 8'h00, 3'd0);
    issue(ACT_REMOVE, 8'hff, 3'd7);
    issue(ACT_RESCHEDULE, 8'hff, 3'd7);
    issue(ACT_SCHEDULE, 8'h00, 3'd0);
    issue(ACT_SCHEDULE, 8'hff, 3'd7);
    issue(ACT_SCHEDULE, 8'h55, 3'd3);
    issue(ACT_SCHEDULE, 8'haa, 3'd3);
    issue(ACT_SCHEDULE, 8'h55, 3'd3);
    issue(ACT_REMOVE, 8'h55, 3'd0);
    issue(ACT_RESCHEDULE, 8'haa, 3'd5);
    for (int i = 0; i < 17; i++) issue(ACT_SCHEDULE, 8'(i), 3'd6);
    issue(ACT_RESCHEDULE, 8'h00, 3'd6);
    repeat (4) issue(ACT_TAKE, 8'h00, 3'd0);

    // Random phase with idling, then back to back
    for (int n = 0; n < 700; n++) begin
      if (n == 600) quiet = 1;
      random_command();
    end
    start <= 1'b0;

    waited = 0;
    while (sb.want_q.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.want_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
